@@ src/fspc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and round functions for the Feistel block cipher.
package fspc_pkg;

  localparam int ROUNDS_DEF = 25;
  localparam int HALF_W     = 32;
  localparam int KEY_W      = 64;
  localparam int RIDX_W     = 5;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 2'd1;

  localparam logic [63:0] KEY_KEEP_MASK = 64'hffff_ffff_ffff_ff00;

  typedef struct packed {
    logic [HALF_W-1:0] plain_left;
    logic [HALF_W-1:0] plain_right;
  } in_req_t;

  typedef struct packed {
    logic [HALF_W-1:0] cipher_left;
    logic [HALF_W-1:0] cipher_right;
  } out_req_t;

  // Everything one round cell holds for a block in flight.
  typedef struct packed {
    logic [HALF_W-1:0] left;
    logic [HALF_W-1:0] right;
    logic [KEY_W-1:0]  key_hi;
    logic [KEY_W-1:0]  key_lo;
  } stage_t;

  function automatic logic [3:0] sbox4(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'h2;
      4'h1: y = 4'h9;
      4'h2: y = 4'h7;
      4'h3: y = 4'he;
      4'h4: y = 4'h1;
      4'h5: y = 4'hc;
      4'h6: y = 4'ha;
      4'h7: y = 4'h0;
      4'h8: y = 4'h4;
      4'h9: y = 4'h3;
      4'ha: y = 4'h8;
      4'hb: y = 4'hd;
      4'hc: y = 4'hf;
      4'hd: y = 4'h6;
      4'he: y = 4'h5;
      4'hf: y = 4'hb;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  function automatic logic [4:0] perm_pos(input int i);
    logic [4:0] p;
    case (i)
      0: p = 5'd20;   1: p = 5'd16;   2: p = 5'd28;   3: p = 5'd24;
      4: p = 5'd17;   5: p = 5'd21;   6: p = 5'd25;   7: p = 5'd29;
      8: p = 5'd22;   9: p = 5'd18;  10: p = 5'd30;  11: p = 5'd26;
      12: p = 5'd19; 13: p = 5'd23;  14: p = 5'd27;  15: p = 5'd31;
      16: p = 5'd11; 17: p = 5'd15;  18: p = 5'd3;   19: p = 5'd7;
      20: p = 5'd14; 21: p = 5'd10;  22: p = 5'd6;   23: p = 5'd2;
      24: p = 5'd9;  25: p = 5'd13;  26: p = 5'd1;   27: p = 5'd5;
      28: p = 5'd12; 29: p = 5'd8;   30: p = 5'd4;   31: p = 5'd0;
      default: p = 5'd0;
    endcase
    return p;
  endfunction

  function automatic logic [HALF_W-1:0] sub32(input logic [HALF_W-1:0] x);
    logic [HALF_W-1:0] y;
    for (int n = 0; n < HALF_W / 4; n++) begin
      y[4*n +: 4] = sbox4(x[4*n +: 4]);
    end
    return y;
  endfunction

  function automatic logic [HALF_W-1:0] perm32(input logic [HALF_W-1:0] x);
    logic [HALF_W-1:0] y;
    for (int i = 0; i < HALF_W; i++) begin
      y[perm_pos(i)] = x[i];
    end
    return y;
  endfunction

endpackage

@@ src/feistel_sbox_perm_cipher64.sv @@
`timescale 1ns / 1ps
// Top level of the 64-bit Feistel S-box/permutation block cipher.
//
// Usage: a plaintext request enters on in_valid/in_stall with in_data and the
// matching ciphertext request leaves on out_valid/out_stall with out_data.
// Each request is encrypted under the key held in two 64-bit registers,
// written through cfg_wr_en/cfg_index/cfg_wdata (index 0 is the upper key
// word, index 1 the lower; other indexes are ignored). Every request starts
// from that key, so requests are independent of each other.
//
// The block is a row of ROUNDS identical round cells; each cell performs one
// round and one key schedule step and hands its block to the next cell every
// cycle while the row advances; one request is accepted per cycle while the
// receiver keeps out_stall low. The last cell's register is the output
// register. When the receiver stalls a waiting result, the whole row holds
// and in_stall rises in the same cycle; bubbles do not slip forward past a
// stall.
//
// Reset (rst_n low, synchronous) clears the key registers and every cell's
// valid flag, so the row comes up empty and ready.
module feistel_sbox_perm_cipher64 #(
  parameter int ROUNDS = fspc_pkg::ROUNDS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  fspc_pkg::in_req_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output fspc_pkg::out_req_t                 out_data,
  input  logic                               cfg_wr_en,
  input  logic [fspc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fspc_pkg::KEY_W-1:0]         cfg_wdata
);
  import fspc_pkg::*;

  logic [KEY_W-1:0] key_upper_r;
  logic [KEY_W-1:0] key_lower_r;
  logic             adv;
  logic             vld_chain [0:ROUNDS];
  stage_t           st_chain  [0:ROUNDS];

  // Key registers; user writes must arrive only while row is empty (unchecked).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_upper_r <= '0;
      key_lower_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_KEY_UPPER: key_upper_r <= cfg_wdata;
        REG_KEY_LOWER: key_lower_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The row advances unless a finished result is being held by the receiver.
  assign adv      = !(vld_chain[ROUNDS] && out_stall);
  assign in_stall = !adv;

  // The first cell sees the fresh block together with the configured key.
  assign vld_chain[0]       = in_valid;
  assign st_chain[0].left   = in_data.plain_left;
  assign st_chain[0].right  = in_data.plain_right;
  assign st_chain[0].key_hi = key_upper_r;
  assign st_chain[0].key_lo = key_lower_r;

  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    fspc_round u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .rd_idx  (RIDX_W'(g)),
      .vld_in  (vld_chain[g]),
      .st_in   (st_chain[g]),
      .vld_out (vld_chain[g+1]),
      .st_out  (st_chain[g+1])
    );
  end

  assign out_valid             = vld_chain[ROUNDS];
  assign out_data.cipher_left  = st_chain[ROUNDS].left;
  assign out_data.cipher_right = st_chain[ROUNDS].right;

  // An accepted request shows up in the first cell on the next edge.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_chain[1])
    else $error("accepted request did not enter the first round cell");

  // A held result freezes the last cell.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("held result changed or vanished");

  // Reset leaves the row empty.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Without a waiting result the row always accepts.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result waiting");

endmodule

@@ src/fspc_round.sv @@
`timescale 1ns / 1ps
// One round cell: applies a Feistel round and a key schedule step, then registers.
module fspc_round (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [4:0]          rd_idx,
  input  logic                vld_in,
  input  fspc_pkg::stage_t    st_in,
  output logic                vld_out,
  output fspc_pkg::stage_t    st_out
);
  import fspc_pkg::*;

  logic              vld_r;
  logic              vld_nxt;
  stage_t            st_r;
  stage_t            st_nxt;
  logic [HALF_W-1:0] mix;
  logic [KEY_W-1:0]  hi_rot;
  logic [KEY_W-1:0]  lo_rot;
  logic [KEY_W-1:0]  hi_sub;

  always_comb begin
    mix = sub32({st_in.left[28:0], st_in.left[31:29]})
        ^ st_in.right
        ^ sub32({st_in.left[7:0], st_in.left[31:8]})
        ^ st_in.key_hi[HALF_W-1:0];

    // The 128-bit key rotates left by 13 across both words.
    hi_rot = {st_in.key_hi[50:0], st_in.key_lo[63:51]};
    lo_rot = {st_in.key_lo[50:0], st_in.key_hi[63:51]};
    hi_sub = (hi_rot & KEY_KEEP_MASK)
           | {56'd0, sbox4(hi_rot[7:4]), sbox4(hi_rot[3:0])};

    st_nxt.right  = perm32(st_in.left);
    st_nxt.left   = perm32(mix);
    st_nxt.key_lo = lo_rot;
    st_nxt.key_hi = {hi_sub[63:59] ^ rd_idx, hi_sub[58:0]};

    vld_nxt = vld_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
    end
  end

  assign vld_out = vld_r;
  assign st_out  = st_r;

endmodule

@@ sim/tb_feistel_sbox_perm_cipher64.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the 64-bit Feistel S-box/permutation block cipher.
module tb_feistel_sbox_perm_cipher64;
  import fspc_pkg::*;

  // Register indexes above the two key words. The block must ignore writes to them.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // 4-bit substitution table. Entry n sits in bits 4n+3..4n.
  localparam logic [63:0] SBOX_NIB = 64'hb56f_d834_0ac1_e792;

  // Destination of each bit in the 32-bit permutation. Entry i sits in bits 5i+4..5i.
  // The list starts with source bit 31 and ends with source bit 0.
  localparam logic [159:0] BIT_DEST = {
    5'd0,  5'd4,  5'd8,  5'd12, 5'd5,  5'd1,  5'd13, 5'd9,
    5'd2,  5'd6,  5'd10, 5'd14, 5'd7,  5'd3,  5'd15, 5'd11,
    5'd31, 5'd27, 5'd23, 5'd19, 5'd26, 5'd30, 5'd18, 5'd22,
    5'd29, 5'd25, 5'd21, 5'd17, 5'd24, 5'd28, 5'd16, 5'd20
  };

  localparam int RAND_PHASES    = 8;
  localparam int ITEMS_PER_PHASE = 130;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KEY_W-1:0]     cfg_wdata = '0;

  // Plaintext requests that wait for the driver, and the ciphertexts still owed by the block.
  in_req_t  plain_q[$];
  out_req_t cipher_q[$];

  // The key as the testbench believes the block holds it. Both words reset to zero.
  logic [KEY_W-1:0] key_hi_cfg = '0;
  logic [KEY_W-1:0] key_lo_cfg = '0;

  // When low, neither side inserts gaps or stalls, so the pipeline runs at full rate.
  bit idle_on = 1'b1;
  int gap_left = 0;
  int stall_left = 0;
  int mismatch_cnt = 0;

  feistel_sbox_perm_cipher64 u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor. The function below works out the ciphertext of one plaintext block
  // from the key words. Every block starts again from the configured key.
  // ---------------------------------------------------------------------------

  // This function substitutes every nibble of a word through the 4-bit S-box.
  function automatic logic [31:0] nib_sub(input logic [31:0] x);
    logic [31:0] y;
    for (int n = 0; n < 8; n++) begin
      y[4*n +: 4] = SBOX_NIB[4*x[4*n +: 4] +: 4];
    end
    return y;
  endfunction

  // This function moves source bit i to bit BIT_DEST[i].
  function automatic logic [31:0] bit_scatter(input logic [31:0] x);
    logic [31:0] y;
    y = '0;
    for (int i = 0; i < 32; i++) begin
      y[BIT_DEST[5*i +: 5]] = x[i];
    end
    return y;
  endfunction

  function automatic out_req_t encrypt_block(input in_req_t p, input logic [63:0] k_hi,
                                             input logic [63:0] k_lo);
    logic [31:0] lh, rh, mix;
    logic [63:0] hi, lo;
    logic [4:0]  rd5;
    out_req_t    c;
    lh = p.plain_left;
    rh = p.plain_right;
    for (int rd = 0; rd < ROUNDS_DEF; rd++) begin
      // The F function uses rotl3 and rotr8 (which equals rotl24) of the left half.
      mix = nib_sub({lh[28:0], lh[31:29]}) ^ rh ^ nib_sub({lh[7:0], lh[31:8]}) ^ k_hi[31:0];
      // Key schedule: rotate the 128-bit key left by 13, substitute the low byte,
      // and fold the round number (modulo 32) into the top five bits.
      hi = {k_hi[50:0], k_lo[63:51]};
      lo = {k_lo[50:0], k_hi[63:51]};
      hi = (hi & KEY_KEEP_MASK) | {56'd0, SBOX_NIB[4*hi[7:4] +: 4], SBOX_NIB[4*hi[3:0] +: 4]};
      rd5 = rd[4:0];
      hi[63:59] = hi[63:59] ^ rd5;
      k_hi = hi;
      k_lo = lo;
      rh = bit_scatter(lh);
      lh = bit_scatter(mix);
    end
    c.cipher_left  = lh;
    c.cipher_right = rh;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. It presents plaintext requests from plain_q. After each accepted request
  // it waits a random number of cycles. A request that has been offered stays
  // unchanged until the block takes it. The expected ciphertext is queued at
  // acceptance. The key cannot change while requests are in flight, so the current
  // key copy is the one that applies.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_plain
    logic take_next;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      take_next = !in_valid;
      if (in_valid && !in_stall) begin
        cipher_q.push_back(encrypt_block(in_data, key_hi_cfg, key_lo_cfg));
        take_next = 1'b1;
      end
      if (take_next) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (plain_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= plain_q.pop_front();
          gap_left <= idle_on ? $urandom_range(0, 7) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. It takes ciphertext requests and checks each against the oldest
  // expectation. After each accepted request it holds out_stall for a random number
  // of cycles. That backs up the whole round pipeline, so stalls land on every stage.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_cipher
    out_req_t want;
    int hold;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      hold = stall_left;
      if (out_valid && !out_stall) begin
        if (cipher_q.size() == 0) begin
          $error("ciphertext %h_%h arrived with no plaintext outstanding",
                 out_data.cipher_left, out_data.cipher_right);
          mismatch_cnt++;
        end else begin
          want = cipher_q.pop_front();
          if (out_data.cipher_left !== want.cipher_left) begin
            $error("cipher_left: expected %h, got %h", want.cipher_left, out_data.cipher_left);
            mismatch_cnt++;
          end
          if (out_data.cipher_right !== want.cipher_right) begin
            $error("cipher_right: expected %h, got %h", want.cipher_right,
                   out_data.cipher_right);
            mismatch_cnt++;
          end
        end
        hold = idle_on ? $urandom_range(0, 7) : 0;
      end
      if (hold != 0) begin
        out_stall  <= 1'b1;
        stall_left <= hold - 1;
      end else begin
        out_stall  <= 1'b0;
        stall_left <= 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. New work is queued at the falling edge, so the driver's view
  // of plain_q never depends on the order of processes at the rising edge.
  // ---------------------------------------------------------------------------
  task automatic push_plain(input logic [31:0] l, input logic [31:0] r);
    in_req_t p;
    p.plain_left  = l;
    p.plain_right = r;
    plain_q.push_back(p);
  endtask

  // This task writes one register. The key copy follows only the two real indexes.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_KEY_UPPER) begin
      key_hi_cfg = val;
    end else if (idx == REG_KEY_LOWER) begin
      key_lo_cfg = val;
    end
  endtask

  task automatic end_cfg();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // This task waits until every queued request is accepted and every ciphertext has
  // come back. Idle clock edges follow, so the next key write finds the pipeline empty.
  task automatic wait_idle();
    do @(negedge clk); while (plain_q.size() != 0 || in_valid || cipher_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // The directed blocks: all zeros, all ones, mixed halves, single bits at each end,
  // alternating patterns and nibble ramps. The all-zero block comes again at the end.
  // Its ciphertext must not depend on the blocks encrypted before it.
  task automatic push_directed();
    @(negedge clk);
    push_plain(32'h0000_0000, 32'h0000_0000);
    push_plain(32'hffff_ffff, 32'hffff_ffff);
    push_plain(32'h0000_0000, 32'hffff_ffff);
    push_plain(32'hffff_ffff, 32'h0000_0000);
    push_plain(32'h8000_0000, 32'h0000_0001);
    push_plain(32'h0000_0001, 32'h8000_0000);
    push_plain(32'h5555_5555, 32'haaaa_aaaa);
    push_plain(32'haaaa_aaaa, 32'h5555_5555);
    push_plain(32'h0123_4567, 32'h89ab_cdef);
    push_plain(32'hfedc_ba98, 32'h7654_3210);
    push_plain(32'h0000_0000, 32'h0000_0000);
  endtask

  // This function returns a random half block. It favors the extremes a little.
  function automatic logic [31:0] rand_half();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence. Reset is asserted once. The first directed pass runs under the
  // zero key that reset leaves behind. The second runs under an all-ones key, and
  // writes to the unused indexes are mixed into its setup. Then come random phases,
  // each under its own key: the extremes first, then random keys. The sender waits
  // until the block is empty before each key change. Every third phase runs with
  // no gaps or stalls at all.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [63:0] hi, lo;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    push_directed();
    wait_idle();

    write_cfg(REG_KEY_UPPER, '1);
    write_cfg(REG_SPARE_A, {$urandom, $urandom});
    write_cfg(REG_KEY_LOWER, '1);
    write_cfg(REG_SPARE_B, {$urandom, $urandom});
    end_cfg();
    push_directed();
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin hi = '0; lo = '0; end
        1: begin hi = '1; lo = '0; end
        2: begin hi = '0; lo = '1; end
        3: begin hi = 64'h8000_0000_0000_0001; lo = 64'h0000_0001_8000_0000; end
        default: begin hi = {$urandom, $urandom}; lo = {$urandom, $urandom}; end
      endcase
      write_cfg(REG_KEY_LOWER, lo);
      write_cfg(REG_KEY_UPPER, hi);
      if (ph == 5) begin
        // Writing an unused index after the real writes must leave the key alone.
        write_cfg(REG_SPARE_B, {$urandom, $urandom});
      end
      end_cfg();
      @(negedge clk);
      idle_on = (ph % 3) != 2;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        push_plain(rand_half(), rand_half());
      end
      wait_idle();
    end

    // This wait outlasts the pipeline, so a stray result would show up before it ends.
    repeat (ROUNDS_DEF + 8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog. The limit gives a large margin over the slowest correct run.
  initial begin : watchdog
    #(2_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule
